>>> rtl/core/lpd_pkg.sv
package lpd_pkg;

   // Fixed field widths of the word formats.
   localparam int CHAN_W = 4;
   localparam int BYTE_W = 8;
   localparam int LEN_W  = 64;

   // Default build values for the top-level parameters.
   localparam int DEF_NUM_CHANNELS = 16;
   localparam int DEF_HEADER_BYTES = 8;

   typedef struct packed {
      logic [CHAN_W-1:0] channel;
      logic [BYTE_W-1:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_channel;
      logic [BYTE_W-1:0] payload_byte;
      logic              first_of_frame;
      logic              last_of_frame;
      logic              empty_frame;
   } rsp_type;

   // Outcome of one context step: whether a result word is produced, and that word.
   typedef struct packed {
      logic    present;
      rsp_type word;
   } ctx_res_type;

endpackage

>>> rtl/core/length_prefix_deframer_unit.sv
// Channel   Direction  Handshake                Word
// req_      in         req_valid / req_ready    req_data : req_type (channel, data_byte)
// rsp_      out        rsp_valid / rsp_ready    rsp_data : rsp_type (one payload byte or
//                                                          an empty-frame mark)
//
// One byte is taken every clock cycle while the result side keeps up. The per-channel
// context read-modify-write sets that rate. A taken byte waits in the input register;
// its result word enters the result register when that byte advances, and is offered
// from then on.
// Reset is synchronous and active high; it clears every context and empties both registers.
// A stalled result side holds back bytes that produce a result; bytes with no result, such as most header bytes, go on.
module length_prefix_deframer_unit
   import lpd_pkg::*;
#(
   parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
   parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // Input register: the byte waiting for its context step.
   logic        in_valid_ff;
   req_type     in_item_ff;

   ctx_res_type res;
   logic        out_free;
   logic        advance;
   logic        load;

   // The held byte moves on when its result, if any, has room in the result register.
   assign advance   = in_valid_ff & (out_free | ~res.present);
   assign load      = advance & res.present;
   assign req_ready = ~in_valid_ff | advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_item_ff <= req_data;
      end
   end

   // Per-channel context store and the step logic that updates it.
   lpd_ctx #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_ctx (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .item  (in_item_ff),
      .res   (res)
   );

   // Result register, which parts the context logic from the result side.
   lpd_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .word      (res.word),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> rtl/core/lpd_ctx.sv
module lpd_ctx
   import lpd_pkg::*;
#(
   parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
   parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  req_type     item,
   output ctx_res_type res
);

   // Only channels that the channel field can name need a context.
   localparam int DEPTH = (NUM_CHANNELS < (1 << CHAN_W)) ? NUM_CHANNELS : (1 << CHAN_W);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int HC_W  = $clog2(HEADER_BYTES + 1);

   localparam logic [CHAN_W:0] CHAN_LIM = (CHAN_W + 1)'(DEPTH);
   localparam logic [HC_W-1:0] HDR_N    = HC_W'(HEADER_BYTES);

   logic [HC_W-1:0]  hc_ff  [DEPTH];
   logic [LEN_W-1:0] len_ff [DEPTH];
   logic             st_ff  [DEPTH];

   logic             in_range;
   logic [IDX_W-1:0] idx;
   logic [HC_W-1:0]  hc;
   logic [LEN_W-1:0] len;
   logic             st;
   logic             in_header;
   logic [LEN_W-1:0] hdr_len;
   logic [HC_W-1:0]  hc_inc;
   logic             hdr_done;
   logic [LEN_W-1:0] rem;
   logic             pay_last;
   logic [HC_W-1:0]  hc_in;
   logic [LEN_W-1:0] len_in;
   logic             st_in;

   assign in_range = {1'b0, item.channel} < CHAN_LIM;
   assign idx      = item.channel[IDX_W-1:0];
   assign hc       = hc_ff[idx];
   assign len      = len_ff[idx];
   assign st       = st_ff[idx];

   assign in_header = hc < HDR_N;
   assign hdr_len   = len | (LEN_W'(item.data_byte) << {3'(hc), 3'b000});
   assign hc_inc    = hc + 1'b1;
   assign hdr_done  = (hc_inc == HDR_N);
   assign rem       = len - 1'b1;
   assign pay_last  = (rem == '0);

   always_comb begin
      res                      = '0;
      res.word.out_channel     = item.channel;
      hc_in                    = hc;
      len_in                   = len;
      st_in                    = st;
      if (in_header) begin
         if (hdr_done && (hdr_len == '0)) begin
            // A zero-length message completes on its last header byte.
            res.present            = in_range;
            res.word.last_of_frame = 1'b1;
            res.word.empty_frame   = 1'b1;
            hc_in                  = '0;
            len_in                 = '0;
            st_in                  = 1'b0;
         end else begin
            hc_in  = hc_inc;
            len_in = hdr_len;
            st_in  = 1'b0;
         end
      end else begin
         res.present             = in_range;
         res.word.payload_byte   = item.data_byte;
         res.word.first_of_frame = ~st;
         res.word.last_of_frame  = pay_last;
         if (pay_last) begin
            hc_in  = '0;
            len_in = '0;
            st_in  = 1'b0;
         end else begin
            len_in = rem;
            st_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            hc_ff[i]  <= '0;
            len_ff[i] <= '0;
            st_ff[i]  <= 1'b0;
         end
      end else if (step && in_range) begin
         hc_ff[idx]  <= hc_in;
         len_ff[idx] <= len_in;
         st_ff[idx]  <= st_in;
      end
   end

endmodule

>>> rtl/core/lpd_out_reg.sv
module lpd_out_reg
   import lpd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type word,
   output logic    free,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    valid_ff;
   rsp_type data_ff;

   // The register can take a new word when empty or when its word leaves now.
   assign free      = ~valid_ff | rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= word;
      end
   end

endmodule

>>> test/length_prefix_deframer_unit_test.sv
module length_prefix_deframer_unit_test;

   import lpd_pkg::*;

   localparam int HDR_LEN        = DEF_HEADER_BYTES;
   localparam int CHANNELS       = DEF_NUM_CHANNELS;
   // Channel fed with an all-ones header, so it stays in its payload for the whole run.
   localparam int ENDLESS_CH     = CHANNELS - 1;
   localparam int RANDOM_WORDS   = 950;
   // Accepted input words after which the receiver holds off for a long stretch.
   localparam int HOLD_AFTER     = 300;
   localparam int HOLD_CYCLES    = 200;
   localparam int QUIET_LIMIT    = 2000;
   localparam int DRAIN_CYCLES   = 16;
   localparam int RESET_CYCLES   = 9;

   // Receiver behaviour, picked anew at random during the run.
   typedef enum logic [1:0] {
      RX_FREE,
      RX_RANDOM,
      RX_SPARSE,
      RX_BUSY
   } rx_mode_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   length_prefix_deframer_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   // Input words still to be offered, and result words the block still owes us.
   req_type wire_bytes [$];
   rsp_type owed_words [$];

   // Our own copy of the per-channel deframing context.
   logic [3:0]  hdr_seen     [CHANNELS];
   logic [63:0] len_left     [CHANNELS];
   logic        payload_open [CHANNELS];

   int fail_count  = 0;
   int words_taken = 0;
   int quiet_cycles = 0;

   // Advances the context of the word's channel by one byte and records the result
   // word it owes, if any. A header byte lands at its byte position in the length;
   // the last header byte of a zero-length message yields a single empty-frame word.
   // A payload byte is passed through, first-marked if it opens the message and
   // last-marked when the remaining count runs out.
   task automatic deframe_byte(input req_type w);
      int          ch;
      logic [63:0] rem;
      rsp_type     r;
      ch = w.channel;
      r = '0;
      r.out_channel = w.channel;
      if (hdr_seen[ch] < HDR_LEN) begin
         len_left[ch] = len_left[ch] | (64'(w.data_byte) << (8 * hdr_seen[ch]));
         hdr_seen[ch] = hdr_seen[ch] + 1'b1;
         payload_open[ch] = 1'b0;
         if (hdr_seen[ch] == HDR_LEN && len_left[ch] == 64'd0) begin
            r.last_of_frame = 1'b1;
            r.empty_frame = 1'b1;
            owed_words.push_back(r);
            hdr_seen[ch] = '0;
         end
      end else begin
         rem = len_left[ch] - 64'd1;
         r.payload_byte = w.data_byte;
         r.first_of_frame = !payload_open[ch];
         r.last_of_frame = (rem == 64'd0);
         owed_words.push_back(r);
         if (rem == 64'd0) begin
            hdr_seen[ch] = '0;
            len_left[ch] = '0;
            payload_open[ch] = 1'b0;
         end else begin
            len_left[ch] = rem;
            payload_open[ch] = 1'b1;
         end
      end
   endtask

   task automatic check_field(input string field_name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field_name, want, got);
         fail_count++;
      end
   endtask

   // Stimulus. The directed opening sends an empty message on channel 0 interleaved
   // with an all-ones header on the endless channel, then a one-byte message with an
   // all-ones payload on channel 1. The random part then interleaves well-formed
   // messages on the other channels with random content, while the endless channel
   // keeps receiving random payload bytes.
   initial begin
      req_type w;
      int      ch;
      int      prev_ch;
      int      pick;
      longint  gen_len [CHANNELS];
      int      gen_pos [CHANNELS];

      for (int i = 0; i < HDR_LEN; i++) begin
         w.channel = 4'd0;
         w.data_byte = 8'h00;
         wire_bytes.push_back(w);
         w.channel = 4'(ENDLESS_CH);
         w.data_byte = 8'hFF;
         wire_bytes.push_back(w);
      end
      for (int i = 0; i <= HDR_LEN; i++) begin
         w.channel = 4'd1;
         w.data_byte = (i == 0) ? 8'h01 : (i == HDR_LEN) ? 8'hFF : 8'h00;
         wire_bytes.push_back(w);
      end

      for (int c = 0; c < CHANNELS; c++) begin
         gen_len[c] = 0;
         gen_pos[c] = 0;
      end
      prev_ch = 0;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         // At least half the time stay on the same channel so that messages also run in one piece.
         ch = ($urandom_range(0, 1) == 0) ? prev_ch : $urandom_range(0, CHANNELS - 1);
         prev_ch = ch;
         w.channel = 4'(ch);
         if (ch == ENDLESS_CH) begin
            w.data_byte = 8'($urandom_range(0, 255));
         end else begin
            if (gen_pos[ch] == 0) begin
               pick = $urandom_range(0, 99);
               if (pick < 20)
                  gen_len[ch] = 0;
               else if (pick < 80)
                  gen_len[ch] = $urandom_range(1, 8);
               else if (pick < 95)
                  gen_len[ch] = $urandom_range(9, 40);
               else
                  gen_len[ch] = $urandom_range(200, 300);
            end
            if (gen_pos[ch] < HDR_LEN)
               w.data_byte = 8'(gen_len[ch] >> (8 * gen_pos[ch]));
            else
               w.data_byte = 8'($urandom_range(0, 255));
            gen_pos[ch]++;
            if (gen_pos[ch] == HDR_LEN + gen_len[ch])
               gen_pos[ch] = 0;
         end
         wire_bytes.push_back(w);
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Wait until every word has gone in and every owed result has come back, then
      // keep the clock running for a drain period so that any surplus word shows.
      while (wire_bytes.size() != 0 || req_valid || owed_words.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Sender. Words go out in bursts of random length, separated by random gaps; a
   // good share of the gaps are empty, so long back-to-back stretches occur too.
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (wire_bytes.size() != 0) begin
            req_data <= wire_bytes.pop_front();
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver. It cycles through its own stall patterns, and once, after enough input
   // words have gone in, it holds off for a long stretch while the sender keeps
   // offering words, so that the result side backs up into the input.
   rx_mode_type rx_mode   = RX_FREE;
   int          rx_tick   = 0;
   int          hold_left = 0;
   logic        hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && words_taken >= HOLD_AFTER) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else begin
         rx_tick <= rx_tick + 1;
         if (rx_tick % 64 == 63)
            rx_mode <= rx_mode_type'($urandom_range(0, 3));
         case (rx_mode)
            RX_FREE:   rsp_ready <= 1'b1;
            RX_RANDOM: rsp_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_ready <= (rx_tick % 4 != 0);
            default:   rsp_ready <= (rx_tick % 3 == 0);
         endcase
      end
   end

   // Monitor. Each accepted input word is run through the predictor; each accepted
   // result word is compared field by field with the oldest owed word. A watchdog
   // ends the run when no word moves on either side for too long.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            hdr_seen[c] = '0;
            len_left[c] = '0;
            payload_open[c] = 1'b0;
         end
         quiet_cycles <= 0;
      end else begin
         if (req_valid && req_ready) begin
            deframe_byte(req_data);
            words_taken <= words_taken + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (owed_words.size() == 0) begin
               $error("result word on channel %0d with nothing owed", rsp_data.out_channel);
               fail_count++;
            end else begin
               want = owed_words.pop_front();
               check_field("out_channel", want.out_channel, rsp_data.out_channel);
               check_field("payload_byte", want.payload_byte, rsp_data.payload_byte);
               check_field("first_of_frame", want.first_of_frame, rsp_data.first_of_frame);
               check_field("last_of_frame", want.last_of_frame, rsp_data.last_of_frame);
               check_field("empty_frame", want.empty_frame, rsp_data.empty_frame);
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

endmodule

>>> sim.f
rtl/core/lpd_pkg.sv
rtl/core/lpd_ctx.sv
rtl/core/lpd_out_reg.sv
rtl/core/length_prefix_deframer_unit.sv
test/length_prefix_deframer_unit_test.sv
